// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the plotter RTL.
// Included by any module that checks its own logic; needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define OPP_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define OPP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define OPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/opp_pkg.sv -----
// Shared constants and types for the OLED page pixel plotter.
// No dependencies; used by opp_point_gen and oled_page_pixel_plotter.
package opp_pkg;

    // Default panel geometry
    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    // Page index width covers the largest supported page count (16)
    localparam int PAGE_W = 4;

    // Item command codes
    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_ROW   = 1'b1;

    // Controller command bytes
    localparam logic [7:0] PAGE_CMD   = 8'hb0;
    localparam logic [7:0] COL_HI_CMD = 8'h10;

    // Panel column offset of the controller RAM
    localparam logic [7:0] COL_OFFSET = 8'd2;

    // Largest bit count of a bitmap row byte
    localparam logic [3:0] ROW_BITS = 4'd8;

    // Current point handed from the point generator to the sequencer
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              on;
        logic [PAGE_W-1:0] page;
        logic [7:0]        col;
        logic [7:0]        bit_mask;
    } point_t;

endpackage

// ----- hw/rtl/opp_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module opp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/opp_point_gen.sv -----
// Point generator: holds one item and yields its on-panel points in order.
// Depends on opp_pkg.
module opp_point_gen #(
    parameter int COLUMNS = opp_pkg::COLUMNS_DEF,
    parameter int PAGES   = opp_pkg::PAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                command,
    input  logic [7:0]          x,
    input  logic [7:0]          y,
    input  logic                pixel_on,
    input  logic [7:0]          pattern,
    input  logic [3:0]          bit_count,
    input  logic                advance,
    output opp_pkg::point_t     point
);

    logic [7:0]                  mask_reg, mask_next, mask_load;
    logic [7:0]                  x_reg;
    logic [opp_pkg::PAGE_W-1:0]  page_reg;
    logic [7:0]                  bit_mask_reg;
    logic                        on_reg;
    logic [2:0]                  idx;
    logic [7:0]                  rest;

    // Build the mask of points that land on the panel
    always_comb
    begin
        logic [3:0] cnt_sat;
        logic       row_ok;
        logic [7:0] xi;
        logic       sel;
        cnt_sat = (bit_count > opp_pkg::ROW_BITS) ? opp_pkg::ROW_BITS : bit_count;
        row_ok  = ({1'b0, y} < 9'(8 * PAGES));
        for (int i = 0; i < 8; i++)
        begin
            xi = x + 8'(i);
            if (command == opp_pkg::CMD_POINT)
                sel = (i == 0);
            else
                sel = pattern[7 - i] && (4'(i) < cnt_sat);
            mask_load[i] = sel && row_ok && ({1'b0, xi} < 9'(COLUMNS));
        end
    end

    // Pick the lowest pending point
    always_comb
    begin
        logic found;
        found = 1'b0;
        idx   = 3'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (mask_reg[i] && !found)
            begin
                idx   = 3'(i);
                found = 1'b1;
            end
        end
        rest = mask_reg & ~(8'd1 << idx);
    end

    // Load a new item or drop the point just plotted
    always_comb
    begin
        if (load)
            mask_next = mask_load;
        else if (advance)
            mask_next = rest;
        else
            mask_next = mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    // Item payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg        <= x;
            page_reg     <= opp_pkg::PAGE_W'(PAGES - 1) - y[6:3];
            bit_mask_reg <= 8'h80 >> y[2:0];
            on_reg       <= pixel_on;
        end
    end

    assign point.valid    = |mask_reg;
    assign point.last     = (rest == 8'd0);
    assign point.on       = on_reg;
    assign point.page     = page_reg;
    assign point.col      = x_reg + {5'd0, idx};
    assign point.bit_mask = bit_mask_reg;

endmodule

// ----- hw/rtl/oled_page_pixel_plotter.sv -----
// Top level of the OLED page pixel plotter: sequencer, frame store, output register.
// Depends on opp_pkg, opp_ram, opp_point_gen and assert_macros.svh.
//
//  channel | handshake           | words
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | command, x, y, pixel_on, pattern, bit_count
//  out     | out_valid/out_stall | out_byte, is_data, last
//
// For each plotted point of a word in: one scan and one frame store read,
// then four output words, set by the frame store read-modify-write and the
// single output register.
// After reset a clearing pass writes zeros over PAGES*COLUMNS entries;
// in_stall stays high throughout.
// A stall on the output holds the sequencer in place; in_stall stays high
// until the last word of the item has been handed to the output register and a scan finds no point left.
`include "assert_macros.svh"

module oled_page_pixel_plotter #(
    parameter int COLUMNS = opp_pkg::COLUMNS_DEF,
    parameter int PAGES   = opp_pkg::PAGES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    input  logic [7:0] x,
    input  logic [7:0] y,
    input  logic       pixel_on,
    input  logic [7:0] pattern,
    input  logic [3:0] bit_count,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       is_data,
    output logic       last
);

    localparam int DEPTH  = PAGES * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    // Output word slots of one plotted point
    localparam logic [1:0] SLOT_PAGE   = 2'd0;
    localparam logic [1:0] SLOT_COL_LO = 2'd1;
    localparam logic [1:0] SLOT_COL_HI = 2'd2;
    localparam logic [1:0] SLOT_DATA   = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [ADDR_W-1:0]           clr_addr_reg, clr_addr_next;
    logic [1:0]                  slot_reg, slot_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_byte_reg, out_byte_next;
    logic                        is_data_reg, is_data_next;
    logic                        last_reg, last_next;
    logic [7:0]                  data_reg, data_next;
    logic [opp_pkg::PAGE_W-1:0]  page_reg, page_next;
    logic [7:0]                  col_reg, col_next;
    logic                        pt_last_reg, pt_last_next;

    opp_pkg::point_t             pt;
    logic                        in_accept;
    logic                        advance;
    logic                        emit_fire;
    logic [ADDR_W-1:0]           pt_addr;
    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [7:0]                  ram_wdata;
    logic [7:0]                  ram_rdata;
    logic [7:0]                  new_byte;
    logic [7:0]                  col_ofs;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign advance   = (state_reg == ST_READ);
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    opp_point_gen #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_point_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_accept),
        .command   (command),
        .x         (x),
        .y         (y),
        .pixel_on  (pixel_on),
        .pattern   (pattern),
        .bit_count (bit_count),
        .advance   (advance),
        .point     (pt)
    );

    // Frame store address of the current point
    assign pt_addr = ADDR_W'(32'(pt.page) * COLUMNS + 32'(pt.col));

    // Modify the byte read back from the frame store
    assign new_byte = pt.on ? (ram_rdata | pt.bit_mask) : (ram_rdata & ~pt.bit_mask);

    // Write zeros while clearing, else write back the modified byte
    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_READ);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : pt_addr;
    assign ram_wdata = (state_reg == ST_CLEAR) ? 8'd0 : new_byte;

    opp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (pt_addr),
        .rdata (ram_rdata)
    );

    assign col_ofs = col_reg + opp_pkg::COL_OFFSET;

    // Sequencer and output register next state
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        is_data_next   = is_data_reg;
        last_next      = last_reg;
        data_next      = data_reg;
        page_next      = page_reg;
        col_next       = col_reg;
        pt_last_next   = pt_last_reg;

        // Drop the output word once taken
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (pt.valid)
                    state_next = ST_READ;
                else
                    state_next = ST_IDLE;
            end
            ST_READ:
            begin
                data_next    = new_byte;
                page_next    = pt.page;
                col_next     = pt.col;
                pt_last_next = pt.last;
                slot_next    = SLOT_PAGE;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    is_data_next   = 1'b0;
                    last_next      = 1'b0;
                    slot_next      = slot_reg + 1'b1;
                    unique case (slot_reg)
                        SLOT_PAGE:
                            out_byte_next = opp_pkg::PAGE_CMD + {4'd0, page_reg};
                        SLOT_COL_LO:
                            out_byte_next = {4'd0, col_ofs[3:0]};
                        SLOT_COL_HI:
                            out_byte_next = opp_pkg::COL_HI_CMD | {4'd0, col_ofs[7:4]};
                        SLOT_DATA:
                        begin
                            out_byte_next = data_reg;
                            is_data_next  = 1'b1;
                            last_next     = pt_last_reg;
                            state_next    = ST_SCAN;
                        end
                        default:
                            out_byte_next = data_reg;
                    endcase
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            slot_reg      <= SLOT_PAGE;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'd0;
            is_data_reg   <= 1'b0;
            last_reg      <= 1'b0;
            data_reg      <= 8'd0;
            page_reg      <= '0;
            col_reg       <= 8'd0;
            pt_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            is_data_reg   <= is_data_next;
            last_reg      <= last_next;
            data_reg      <= data_next;
            page_reg      <= page_next;
            col_reg       <= col_next;
            pt_last_reg   <= pt_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign is_data   = is_data_reg;
    assign last      = last_reg;

    // Frame store is written only by the clearing pass or a write-back
    `OPP_ASSERT_SAME(a_we_src, clk, rst_n, ram_we, (state_reg == ST_CLEAR) || (state_reg == ST_READ), "frame store written outside clear or write-back")
    // The closing word of an item is always a data word
    `OPP_ASSERT_SAME(a_last_is_data, clk, rst_n, out_valid_reg && last_reg, is_data_reg, "last word is not a data word")
    // A write-back follows a scan that found a point
    `OPP_ASSERT_SAME(a_read_after_scan, clk, rst_n, state_reg == ST_READ, $past(state_reg) == ST_SCAN && $past(pt.valid), "write-back without a scanned point")
    // Page command word is followed by the column low word
    `OPP_ASSERT_NEXT(a_slot_order, clk, rst_n, emit_fire && (slot_reg == SLOT_PAGE), slot_reg == SLOT_COL_LO, "output word slots out of order")

endmodule
